// ===== sv/nst_pkg.sv =====
package nst_pkg;

  localparam int SLOT_COUNT = 16;
  localparam int NAME_BYTES = 16;
  localparam int NAME_W     = NAME_BYTES * 8;
  localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W      = $clog2(SLOT_COUNT + 1);
  localparam int QTY_W      = 8;

  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;

  localparam logic [7:0] BYTE_EMPTY = 8'h00;
  localparam logic [7:0] BYTE_BLANK = 8'hFF;

  // write request into the slot store
  typedef struct packed {
    logic              name_we;
    logic              qty_we;
    logic [SLOT_W-1:0] addr;
    logic [NAME_W-1:0] name;
    logic [QTY_W-1:0]  qty;
  } nst_wr_t;

  // a slot is free when its first byte is 0x00 or 0xFF
  function automatic logic slot_free(input logic [NAME_W-1:0] name);
    return (name[7:0] == BYTE_EMPTY) || (name[7:0] == BYTE_BLANK);
  endfunction

  // bit i set when no zero byte precedes byte i in the query
  function automatic logic [NAME_BYTES-1:0] name_mask(input logic [NAME_W-1:0] q);
    logic [NAME_BYTES-1:0] m;
    logic                  live;
    live = 1'b1;
    for (int i = 0; i < NAME_BYTES; i++) begin
      m[i] = live;
      if (q[8*i +: 8] == BYTE_EMPTY) live = 1'b0;
    end
    return m;
  endfunction

endpackage

// ===== sv/nst_mem.sv =====
module nst_mem import nst_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              rd_en,
  input  logic [SLOT_W-1:0] rd_addr,
  output logic [NAME_W-1:0] rd_name,
  output logic [QTY_W-1:0]  rd_qty,
  input  nst_wr_t           wr
);

  logic [NAME_W-1:0]     name_mem [SLOT_COUNT];
  logic [QTY_W-1:0]      qty_mem  [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] name_vld;
  logic [SLOT_COUNT-1:0] qty_vld;

  // unwritten entries read as blank (all ones)
  always_ff @(posedge clk) begin
    if (wr.name_we) begin
      name_mem[wr.addr] <= wr.name;
    end
    if (wr.qty_we) begin
      qty_mem[wr.addr] <= wr.qty;
    end
    if (rd_en) begin
      rd_name <= name_vld[rd_addr] ? name_mem[rd_addr] : '1;
      rd_qty  <= qty_vld[rd_addr] ? qty_mem[rd_addr] : '1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      name_vld <= '0;
      qty_vld  <= '0;
    end else begin
      if (wr.name_we) name_vld[wr.addr] <= 1'b1;
      if (wr.qty_we)  qty_vld[wr.addr]  <= 1'b1;
    end
  end

endmodule

// ===== sv/named_slot_table.sv =====
// Table of 16 slots, each a 16-byte name plus a quantity byte, held in a
// synchronous RAM with a registered read port and a separate write port.
// One request is handled at a time. Add and remove walk every slot in
// order, one RAM read per cycle, then write back and load the result into
// the output register. Read touches one slot: RAM read, check, output load.
// An unused command code goes straight to the output load.
// A new request is taken the cycle after the previous result is loaded,
// even if that result still sits in the output register. The RAM
// needs no clearing pass: per-entry valid bits make unwritten slots read
// as blank (all 0xFF) right after reset. occupied_count is kept as a
// running count, updated on the write-back.
module named_slot_table import nst_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  cmd,
  input  logic [63:0] name_low,
  input  logic [63:0] name_high,
  input  logic [7:0]  quantity,
  input  logic [7:0]  slot_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        ok,
  output logic [63:0] out_name_low,
  output logic [63:0] out_name_high,
  output logic [7:0]  out_quantity,
  output logic [4:0]  occupied_count
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_WRITE = 6'b000100,
    S_READ  = 6'b001000,
    S_RDCHK = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state;

  // request registers
  logic [1:0]        cmd_q;
  logic [NAME_W-1:0] q_name;
  logic [QTY_W-1:0]  qty_q;
  logic [7:0]        idx_q;

  // scan bookkeeping
  logic [SLOT_W:0]   scan_cnt;
  logic              chk_valid;
  logic [SLOT_W-1:0] chk_addr;
  logic              hit_found;
  logic [SLOT_W-1:0] hit_idx;
  logic [NAME_W-1:0] hit_name;
  logic              hit_free;
  logic              free_found;
  logic [SLOT_W-1:0] free_idx;

  logic [CNT_W-1:0]  count_q;

  // result waiting for the output register
  logic              res_ok;
  logic [NAME_W-1:0] res_name;
  logic [QTY_W-1:0]  res_qty;

  // RAM side
  logic              rd_en;
  logic [SLOT_W-1:0] rd_addr;
  logic [NAME_W-1:0] rd_name;
  logic [QTY_W-1:0]  rd_qty;
  nst_wr_t           wr;

  logic [NAME_BYTES-1:0] q_mask;
  logic [NAME_W-1:0]     q_pad;
  logic                  rd_match;
  logic                  rd_free;
  logic                  add_go;
  logic                  rm_go;
  logic [127:0]          res_wide;

  assign in_ready = (state == S_IDLE);

  // Query mask: bytes up to and including the first zero take part in the
  // compare; on add, everything past the terminator is stored as zero.
  always_comb begin
    q_mask = name_mask(q_name);
    for (int i = 0; i < NAME_BYTES; i++) begin
      q_pad[8*i +: 8] = q_mask[i] ? q_name[8*i +: 8] : BYTE_EMPTY;
    end
  end

  always_comb begin
    rd_match = 1'b1;
    for (int i = 0; i < NAME_BYTES; i++) begin
      if (q_mask[i] && (rd_name[8*i +: 8] != q_name[8*i +: 8])) rd_match = 1'b0;
    end
    rd_free = slot_free(rd_name);
  end

  // Scan issues slot reads in order; read of a single slot for CMD_READ.
  always_comb begin
    rd_en   = ((state == S_SCAN) && (scan_cnt < (SLOT_W+1)'(SLOT_COUNT))) ||
              (state == S_READ);
    rd_addr = (state == S_READ) ? idx_q[SLOT_W-1:0] : scan_cnt[SLOT_W-1:0];
  end

  // Add only if nothing matched and a free slot exists. Remove of an
  // already-free matching slot succeeds without a write.
  assign add_go = (cmd_q == CMD_ADD) && !hit_found && free_found;
  assign rm_go  = (cmd_q == CMD_REMOVE) && hit_found && !hit_free;

  always_comb begin
    wr = '0;
    if (state == S_WRITE) begin
      if (add_go) begin
        wr.name_we = 1'b1;
        wr.qty_we  = 1'b1;
        wr.addr    = free_idx;
        wr.name    = q_pad;
        wr.qty     = qty_q;
      end else if (rm_go) begin
        wr.name_we = 1'b1;
        wr.addr    = hit_idx;
        wr.name    = {hit_name[NAME_W-1:8], BYTE_EMPTY};
      end
    end
  end

  nst_mem u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_name (rd_name),
    .rd_qty  (rd_qty),
    .wr      (wr)
  );

  assign res_wide = 128'(res_name);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      count_q    <= '0;
      chk_valid  <= 1'b0;
      hit_found  <= 1'b0;
      free_found <= 1'b0;
      scan_cnt   <= '0;
    end else begin
      // output register loads in S_DONE, empties when taken
      if ((state == S_DONE) && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      chk_valid <= (state == S_SCAN) && rd_en;
      chk_addr  <= scan_cnt[SLOT_W-1:0];

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd_q      <= cmd;
            q_name     <= NAME_W'({name_high, name_low});
            qty_q      <= quantity;
            idx_q      <= slot_index;
            hit_found  <= 1'b0;
            free_found <= 1'b0;
            scan_cnt   <= '0;
            res_ok     <= 1'b0;
            res_name   <= '0;
            res_qty    <= '0;
            if (cmd == CMD_ADD || cmd == CMD_REMOVE) begin
              state <= S_SCAN;
            end else if (cmd == CMD_READ) begin
              state <= S_READ;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_SCAN: begin
          if (scan_cnt < (SLOT_W+1)'(SLOT_COUNT)) scan_cnt <= scan_cnt + 1'b1;
          if (chk_valid) begin
            // first matching slot, free ones included
            if (rd_match && !hit_found) begin
              hit_found <= 1'b1;
              hit_idx   <= chk_addr;
              hit_name  <= rd_name;
              hit_free  <= rd_free;
            end
            if (rd_free && !free_found) begin
              free_found <= 1'b1;
              free_idx   <= chk_addr;
            end
            if (chk_addr == SLOT_W'(SLOT_COUNT - 1)) state <= S_WRITE;
          end
        end
        S_WRITE: begin
          if (cmd_q == CMD_ADD) begin
            res_ok <= add_go;
            // a stored name starting with 0x00 or 0xFF still reads as free
            if (add_go && !slot_free(q_pad)) count_q <= count_q + 1'b1;
          end else begin
            res_ok <= hit_found;
            if (rm_go) count_q <= count_q - 1'b1;
          end
          state <= S_DONE;
        end
        S_READ: begin
          state <= S_RDCHK;
        end
        S_RDCHK: begin
          if ((idx_q < 8'(SLOT_COUNT)) && !rd_free) begin
            res_ok   <= 1'b1;
            res_name <= rd_name;
            res_qty  <= rd_qty;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            ok             <= res_ok;
            out_name_low   <= res_wide[63:0];
            out_name_high  <= res_wide[127:64];
            out_quantity   <= res_qty;
            occupied_count <= 5'(count_q);
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // running count can never pass the table size
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count_q <= CNT_W'(SLOT_COUNT))
    else $error("occupied count out of range");

  // the count only moves on a write-back, and by one at most
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (state != S_WRITE) |=> $stable(count_q))
    else $error("occupied count changed outside write-back");

  // no RAM write while a new request could be taken
  a_write_busy: assert property (@(posedge clk) disable iff (rst)
    (wr.name_we || wr.qty_we) |-> !in_ready)
    else $error("slot write while idle");

endmodule

// ===== tb/sv/named_slot_table_test.sv =====
`timescale 1ns / 100ps

// Self-checking bench for named_slot_table.
// A queue of pending requests feeds a clocked driver; every accepted request
// runs through a shadow copy of the slot table to predict its answer, which
// a clocked monitor compares field by field against the DUT output.
module named_slot_table_test;
  import nst_pkg::*;

  localparam logic [1:0] CMD_UNUSED  = 2'd3;   // reserved code, must answer ok = 0
  localparam int         POOL_SIZE   = 24;     // > SLOT_COUNT so the table can fill
  localparam int         RANDOM_REQS = 1300;
  localparam int         BURST_LEN   = 25;     // add bias flips every burst
  localparam int         HOLD_AT     = 200;    // answers seen before the long stall
  localparam int         HOLD_CYCLES = 400;
  localparam int         QUIET_LO    = 700;    // window with no random idling
  localparam int         QUIET_HI    = 1000;
  localparam int         DRAIN_CYCLES = 40;    // settle time after the last answer is checked
  localparam int         STALL_LIMIT  = 2000;  // well above HOLD_CYCLES + latency

  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] name_lo;
    logic [63:0] name_hi;
    logic [7:0]  qty;
    logic [7:0]  slot;
  } nst_request_t;

  typedef struct packed {
    logic             ok;
    logic [63:0]      name_lo;
    logic [63:0]      name_hi;
    logic [7:0]       qty;
    logic [CNT_W-1:0] count;
  } nst_answer_t;

  // ---------------------------------------------------------------------------
  // DUT and its pins; everything starts at a known value
  // ---------------------------------------------------------------------------
  logic        clk        = 1'b0;
  logic        rst        = 1'b1;
  logic        in_valid   = 1'b0;
  logic        in_ready;
  logic [1:0]  cmd        = CMD_ADD;
  logic [63:0] name_low   = '0;
  logic [63:0] name_high  = '0;
  logic [7:0]  quantity   = '0;
  logic [7:0]  slot_index = '0;
  logic        out_valid;
  logic        out_ready  = 1'b0;
  logic        ok;
  logic [63:0] out_name_low;
  logic [63:0] out_name_high;
  logic [7:0]  out_quantity;
  logic [4:0]  occupied_count;

  named_slot_table u_dut (.*);

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Bench state
  // ---------------------------------------------------------------------------
  nst_request_t      pending_requests[$];   // filled by stimulus, drained by driver
  nst_answer_t       expected_answers[$];   // pushed on accept, popped on result
  nst_request_t      on_wire;               // request currently offered on the pins
  logic [NAME_W-1:0] shadow_names[SLOT_COUNT];
  logic [7:0]        shadow_qty[SLOT_COUNT];
  int                requests_sent   = 0;
  int                accepted_count  = 0;
  int                answers_checked = 0;
  int                mismatch_count  = 0;
  int                stall_cycles    = 0;

  // ---------------------------------------------------------------------------
  // Shadow table
  // ---------------------------------------------------------------------------

  // Slot is free when its leading byte is 0x00 (removed) or 0xFF (blank).
  function automatic logic is_vacant(input logic [NAME_W-1:0] stored);
    return stored[7:0] == BYTE_EMPTY || stored[7:0] == BYTE_BLANK;
  endfunction

  // Bytes must agree up to and including the query's first zero byte.
  // Garbage past the terminator in the query is ignored.
  function automatic logic query_matches(input logic [NAME_W-1:0] stored,
                                         input logic [NAME_W-1:0] q);
    logic same;
    logic live;
    same = 1'b1;
    live = 1'b1;
    for (int i = 0; i < NAME_BYTES; i++) begin
      if (live) begin
        if (stored[8*i +: 8] != q[8*i +: 8]) begin
          same = 1'b0;
          live = 1'b0;
        end
        if (q[8*i +: 8] == BYTE_EMPTY) live = 1'b0;
      end
    end
    return same;
  endfunction

  // Applies one request to the shadow table and returns the answer it gives.
  function automatic nst_answer_t predict_answer(input nst_request_t r);
    nst_answer_t       a;
    logic [NAME_W-1:0] q;
    logic              ended;
    int                hit_slot;
    int                free_slot;
    a = '0;
    q = {r.name_hi, r.name_lo};
    hit_slot = -1;
    free_slot = -1;
    // walk downward so the lowest matching / free slot wins
    for (int s = SLOT_COUNT - 1; s >= 0; s--) begin
      if (query_matches(shadow_names[s], q)) hit_slot = s;
      if (is_vacant(shadow_names[s])) free_slot = s;
    end
    case (r.op)
      CMD_ADD: begin
        // duplicate or full table: nothing written
        if (hit_slot < 0 && free_slot >= 0) begin
          ended = 1'b0;
          for (int i = 0; i < NAME_BYTES; i++) begin
            if (q[8*i +: 8] == BYTE_EMPTY) ended = 1'b1;
            shadow_names[free_slot][8*i +: 8] = ended ? BYTE_EMPTY : q[8*i +: 8];
          end
          shadow_qty[free_slot] = r.qty;
          a.ok = 1'b1;
        end
      end
      CMD_REMOVE: begin
        // a match on an already-free slot still succeeds, with no write
        if (hit_slot >= 0) begin
          if (!is_vacant(shadow_names[hit_slot])) shadow_names[hit_slot][7:0] = BYTE_EMPTY;
          a.ok = 1'b1;
        end
      end
      CMD_READ: begin
        if (r.slot < SLOT_COUNT && !is_vacant(shadow_names[r.slot[SLOT_W-1:0]])) begin
          {a.name_hi, a.name_lo} = shadow_names[r.slot[SLOT_W-1:0]];
          a.qty = shadow_qty[r.slot[SLOT_W-1:0]];
          a.ok  = 1'b1;
        end
      end
      default: ;
    endcase
    for (int s = 0; s < SLOT_COUNT; s++)
      if (!is_vacant(shadow_names[s])) a.count = a.count + 1'b1;
    return a;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offers the head of the pending queue; valid holds until accepted
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_requests
    logic quiet;
    if (rst) begin
      in_valid <= 1'b0;
      for (int s = 0; s < SLOT_COUNT; s++) begin
        shadow_names[s] = '1;
        shadow_qty[s]   = '1;
      end
    end else begin
      if (in_valid && in_ready) begin
        expected_answers.push_back(predict_answer(on_wire));
        accepted_count++;
      end
      if (!in_valid || in_ready) begin
        quiet = accepted_count >= QUIET_LO && accepted_count < QUIET_HI;
        if (pending_requests.size() > 0 && (quiet || $urandom_range(0, 99) >= 9)) begin
          on_wire    = pending_requests.pop_front();
          in_valid   <= 1'b1;
          cmd        <= on_wire.op;
          name_low   <= on_wire.name_lo;
          name_high  <= on_wire.name_hi;
          quantity   <= on_wire.qty;
          slot_index <= on_wire.slot;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each answer against the oldest prediction
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what);
    $display("ERROR answer %0d: %s", answers_checked, what);
    mismatch_count++;
  endtask

  task automatic check_field(input string field, input logic [63:0] seen,
                             input logic [63:0] want);
    if (seen !== want)
      report_mismatch($sformatf("%s got %h want %h", field, seen, want));
  endtask

  always @(posedge clk) begin : check_answers
    nst_answer_t want;
    int          hold_left;
    logic        hold_done;
    logic        quiet;
    if (rst) begin
      out_ready <= 1'b0;
      hold_left = 0;
      hold_done = 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_answers.size() == 0) begin
          report_mismatch("answer with no request outstanding");
        end else begin
          want = expected_answers.pop_front();
          check_field("ok",             64'(ok),             64'(want.ok));
          check_field("out_name_low",   out_name_low,        want.name_lo);
          check_field("out_name_high",  out_name_high,       want.name_hi);
          check_field("out_quantity",   64'(out_quantity),   64'(want.qty));
          check_field("occupied_count", 64'(occupied_count), 64'(want.count));
          answers_checked++;
        end
      end
      // one long back-pressure episode while requests keep coming
      if (!hold_done && answers_checked >= HOLD_AT && pending_requests.size() > 0) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        quiet = answers_checked >= QUIET_LO && answers_checked < QUIET_HI;
        out_ready <= quiet || $urandom_range(0, 99) >= 9;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: no traffic on either side for too long ends the run
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // len nonzero bytes then zero padding; len 0 is the empty name
  function automatic logic [NAME_W-1:0] make_name(input int len);
    logic [NAME_W-1:0] n;
    n = '0;
    for (int i = 0; i < len && i < NAME_BYTES; i++) n[8*i +: 8] = 8'($urandom_range(1, 255));
    return n;
  endfunction

  task automatic queue_request(input logic [1:0] op, input logic [NAME_W-1:0] nm,
                               input logic [7:0] qty, input logic [7:0] slot);
    pending_requests.push_back('{op, nm[63:0], nm[127:64], qty, slot});
    requests_sent++;
  endtask

  // sender pause: nothing new until every answer is back
  task automatic wait_drained();
    while (answers_checked < requests_sent) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [NAME_W-1:0] name_pool[POOL_SIZE];
    logic [NAME_W-1:0] long_name;
    logic [NAME_W-1:0] short_name;
    logic [NAME_W-1:0] tail_name;
    logic [NAME_W-1:0] nm;
    logic [1:0]        op;
    logic [7:0]        slot;
    logic              hit;
    int                add_bias;
    int                roll;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Pool with some names cut short by a zero so terminator matching gets exercised
    for (int k = 0; k < POOL_SIZE; k++) begin
      name_pool[k] = make_name($urandom_range(1, NAME_BYTES));
      if (k % 4 == 1)
        for (int i = $urandom_range(1, NAME_BYTES - 1); i < NAME_BYTES; i++)
          name_pool[k][8*i +: 8] = BYTE_EMPTY;
    end

    // ---- directed ----
    long_name  = make_name(NAME_BYTES);
    short_name = make_name(1);
    tail_name  = {{13{8'hAA}}, BYTE_EMPTY, 8'h43, 8'h42};   // "BC" + junk past terminator
    queue_request(CMD_READ,   '0, 8'h00, 8'd0);        // blank slot after reset
    queue_request(CMD_READ,   '0, 8'hFF, 8'd255);      // far out of range
    queue_request(CMD_REMOVE, short_name, 8'h00, 8'd0);   // absent
    queue_request(CMD_ADD,    long_name, 8'hFF, 8'd0);    // full-length name, max qty
    queue_request(CMD_ADD,    long_name, 8'h01, 8'd0);    // duplicate
    queue_request(CMD_ADD,    short_name, 8'h00, 8'd0);   // one-byte name, zero qty
    queue_request(CMD_ADD,    tail_name, 8'h77, 8'd0);    // stored zero padded
    queue_request(CMD_ADD,    '1, 8'h5A, 8'd0);           // 0xFF lead: matches a blank slot, not written
    queue_request(CMD_READ,   '0, 8'h00, 8'd3);
    queue_request(CMD_ADD,    '0, 8'h33, 8'd0);           // empty name is written to slot 3, still reads free
    queue_request(CMD_READ,   '0, 8'h00, 8'd0);
    queue_request(CMD_READ,   '0, 8'h00, 8'd1);
    queue_request(CMD_READ,   '0, 8'h00, 8'd2);
    queue_request(CMD_REMOVE, long_name, 8'h00, 8'd0);
    queue_request(CMD_REMOVE, long_name, 8'h00, 8'd0);    // now absent
    queue_request(CMD_REMOVE, '0, 8'h00, 8'd0);           // hits removed slot, no write
    queue_request(CMD_ADD,    '0, 8'h10, 8'd0);           // empty name matches removed slot
    queue_request(CMD_READ,   '0, 8'h00, 8'd0);           // removed slot reads free
    queue_request(CMD_UNUSED, {$urandom, $urandom, $urandom, $urandom}, 8'hC3, 8'd1);
    queue_request(CMD_READ,   '0, 8'h00, 8'd15);
    queue_request(CMD_READ,   '0, 8'h00, 8'd16);          // first index past the table
    queue_request(CMD_ADD,    {{13{8'h55}}, BYTE_EMPTY, 8'h43, 8'h42}, 8'h01, 8'd0); // dup
    queue_request(CMD_REMOVE, short_name, 8'h00, 8'd0);
    wait_drained();

    // ---- random: bursts alternate between filling and draining the table ----
    add_bias = 70;
    for (int n = 0; n < RANDOM_REQS; n++) begin
      if (n % BURST_LEN == 0) add_bias = (add_bias == 70) ? 25 : 70;
      if (n == RANDOM_REQS / 2) wait_drained();

      roll = $urandom_range(0, 99);
      if (roll < 2)                            op = CMD_UNUSED;
      else if (roll < add_bias)                op = CMD_ADD;
      else if (roll < add_bias + (100 - add_bias) / 2) op = CMD_REMOVE;
      else                                     op = CMD_READ;

      roll = $urandom_range(0, 99);
      if (roll < 80) begin
        nm = name_pool[$urandom_range(0, POOL_SIZE - 1)];
      end else if (roll < 88) begin
        nm = make_name($urandom_range(0, NAME_BYTES));
        if ($urandom_range(0, 3) == 0) nm[7:0] = BYTE_BLANK;
      end else if (roll < 94) begin
        nm = {$urandom, $urandom, $urandom, $urandom};
      end else begin
        // known name with junk after its terminator
        nm  = name_pool[$urandom_range(0, POOL_SIZE - 1)];
        hit = 1'b0;
        for (int i = 0; i < NAME_BYTES; i++) begin
          if (hit) nm[8*i +: 8] = 8'($urandom);
          else if (nm[8*i +: 8] == BYTE_EMPTY) hit = 1'b1;
        end
      end

      if (op == CMD_READ && $urandom_range(0, 9) != 0)
        slot = 8'($urandom_range(0, SLOT_COUNT - 1));
      else slot = 8'($urandom_range(0, 255));

      queue_request(op, nm, 8'($urandom_range(0, 255)), slot);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/nst_pkg.sv
sv/nst_mem.sv
sv/named_slot_table.sv
tb/sv/named_slot_table_test.sv
